/* rtl/variable_width_alu_macros.svh */
// ----------------------------------------------------------------------------
// Variable width ALU assertion macros
// Shared concurrent assertion helpers, clocked on clk, disabled in reset.
// ----------------------------------------------------------------------------
`ifndef VARIABLE_WIDTH_ALU_MACROS_SVH
`define VARIABLE_WIDTH_ALU_MACROS_SVH
`ifndef SYNTH
// same-cycle implication
`define VWA_ASSERT_IMP(lbl, ante, cons) \
  lbl: assert property (@(posedge clk) disable iff (!rst_n) (ante) |-> (cons)) \
    else $error("assertion failed");
// next-cycle implication
`define VWA_ASSERT_NXT(lbl, ante, cons) \
  lbl: assert property (@(posedge clk) disable iff (!rst_n) (ante) |=> (cons)) \
    else $error("assertion failed");
`else
`define VWA_ASSERT_IMP(lbl, ante, cons)
`define VWA_ASSERT_NXT(lbl, ante, cons)
`endif
`endif

/* rtl/vwa_pkg.sv */
// ----------------------------------------------------------------------------
// vwa_pkg
// Types, opcodes and constants of the variable width ALU.
// ----------------------------------------------------------------------------
package vwa_pkg;

  localparam int DATA_W     = 64;
  localparam int MAX_WIDTH  = 64;
  localparam int WID_W      = 7;
  localparam int OP_W       = 5;
  localparam int SH_W       = $clog2(DATA_W);
  localparam int HALF_W     = DATA_W / 2;
  localparam int DIV_STAGES = DATA_W;

  typedef enum logic [OP_W-1:0] {
    OP_NEG  = 5'd0,
    OP_RAND = 5'd1,
    OP_ROR  = 5'd2,
    OP_RXOR = 5'd3,
    OP_INV  = 5'd4,
    OP_LNOT = 5'd5,
    OP_PLUS = 5'd6,
    OP_ADD  = 5'd7,
    OP_SUB  = 5'd8,
    OP_MUL  = 5'd9,
    OP_DIV  = 5'd10,
    OP_AND  = 5'd11,
    OP_OR   = 5'd12,
    OP_XOR  = 5'd13,
    OP_EQ   = 5'd14,
    OP_GE   = 5'd15,
    OP_LE   = 5'd16,
    OP_LT   = 5'd17,
    OP_GT   = 5'd18,
    OP_LSR  = 5'd19,
    OP_ASR  = 5'd20
  } op_t;

  typedef struct packed {
    logic [OP_W-1:0]   action;
    logic [DATA_W-1:0] operand_a;
    logic [DATA_W-1:0] operand_b;
    logic [WID_W-1:0]  op_width;
    logic              is_signed;
  } in_t;

  typedef struct packed {
    logic [DATA_W-1:0] result_bits;
    logic              fault;
  } out_t;

  // decoded operands after the front stage
  typedef struct packed {
    logic [OP_W-1:0]   op;
    logic [WID_W-1:0]  w;
    logic [DATA_W-1:0] mask;
    logic [DATA_W-1:0] top;
    logic [DATA_W-1:0] a;
    logic [DATA_W-1:0] b;
    logic [DATA_W-1:0] aa;
    logic [DATA_W-1:0] ba;
    logic              sgn;
    logic              an;
    logic              bn;
    logic              fault;
  } prep_t;

  // data carried alongside the divider
  typedef struct packed {
    logic [OP_W-1:0]   op;
    logic [DATA_W-1:0] mask;
    logic              an;
    logic              bn;
    logic              fault;
    logic [DATA_W-1:0] simple;
    logic [DATA_W-1:0] prod;
  } side_t;

endpackage

/* rtl/variable_width_alu.sv */
// ----------------------------------------------------------------------------
// variable_width_alu
// Pipelined integer ALU at a selectable operand width of 1 to 64 bits.
// ----------------------------------------------------------------------------
// One beat is accepted per cycle unless the output stalls, and results leave
// in order through one front stage, two multiplier stages, 64 divider stages
// (one quotient bit each) and the output register. All opcodes go through the
// same depth. A stall on the output freezes the whole pipeline.
module variable_width_alu import vwa_pkg::*; (
  input  logic clk,
  input  logic rst_n,
  input  logic in_valid,
  output logic in_stall,
  input  in_t  in_data,
  output logic out_valid,
  input  logic out_stall,
  output out_t out_data
);

  `include "variable_width_alu_macros.svh"

  logic              adv;
  prep_t             prep_c;
  logic              v1_r, v2_r, v3_r;
  prep_t             p1_r, p2_r;
  logic [DATA_W-1:0] simple_nxt, simple2_r;
  logic [DATA_W-1:0] prod;
  side_t             side3_r, side3_nxt, side_o;
  logic [DATA_W-1:0] aa3_r, ba3_r, quo;
  logic              vo;
  logic              out_valid_r;
  out_t              out_data_r, out_data_nxt;

  // global advance
  assign adv      = !(out_valid_r && out_stall);
  assign in_stall = !adv;

  vwa_prep u_prep (.din(in_data), .dout(prep_c));

  // stage 1: decoded operands
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      v1_r <= 1'b0;
    end else if (adv) begin
      v1_r <= in_valid;
    end
  end
  always_ff @(posedge clk) begin
    if (adv) begin
      p1_r <= prep_c;
    end
  end

  // combinational ops on the stage 1 operands
  always_comb begin
    logic [DATA_W-1:0] ak, bk;
    logic              big;
    logic [SH_W-1:0]   sa;
    ak  = p1_r.sgn ? (p1_r.a ^ p1_r.top) : p1_r.a;
    bk  = p1_r.sgn ? (p1_r.b ^ p1_r.top) : p1_r.b;
    big = p1_r.b >= DATA_W'(p1_r.w);
    sa  = p1_r.b[SH_W-1:0];
    case (p1_r.op)
      OP_NEG:  simple_nxt = ~p1_r.a + DATA_W'(1);
      OP_RAND: simple_nxt = DATA_W'(p1_r.a == p1_r.mask);
      OP_ROR:  simple_nxt = DATA_W'(p1_r.a != '0);
      OP_RXOR: simple_nxt = DATA_W'(^p1_r.a);
      OP_INV:  simple_nxt = ~p1_r.a;
      OP_LNOT: simple_nxt = DATA_W'(p1_r.a == '0);
      OP_PLUS: simple_nxt = p1_r.a;
      OP_ADD:  simple_nxt = p1_r.a + p1_r.b;
      OP_SUB:  simple_nxt = p1_r.a - p1_r.b;
      OP_AND:  simple_nxt = p1_r.a & p1_r.b;
      OP_OR:   simple_nxt = p1_r.a | p1_r.b;
      OP_XOR:  simple_nxt = p1_r.a ^ p1_r.b;
      OP_EQ:   simple_nxt = DATA_W'(p1_r.a == p1_r.b);
      OP_GE:   simple_nxt = DATA_W'(ak >= bk);
      OP_LE:   simple_nxt = DATA_W'(ak <= bk);
      OP_LT:   simple_nxt = DATA_W'(ak < bk);
      OP_GT:   simple_nxt = DATA_W'(ak > bk);
      OP_LSR:  simple_nxt = big ? '0 : (p1_r.a >> sa);
      OP_ASR: begin
        if (big) begin
          simple_nxt = p1_r.an ? p1_r.mask : '0;
        end else begin
          simple_nxt = (p1_r.a >> sa) |
                       (p1_r.an ? (p1_r.mask & ~(p1_r.mask >> sa)) : '0);
        end
      end
      default: simple_nxt = '0;
    endcase
  end

  // stage 2
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      v2_r <= 1'b0;
    end else if (adv) begin
      v2_r <= v1_r;
    end
  end
  always_ff @(posedge clk) begin
    if (adv) begin
      p2_r      <= p1_r;
      simple2_r <= simple_nxt;
    end
  end

  vwa_mul u_mul (
    .clk (clk),
    .en  (adv),
    .aa  (p1_r.aa),
    .ba  (p1_r.ba),
    .prod(prod)
  );

  // stage 3: sideband for the divider
  always_comb begin
    side3_nxt        = '0;
    side3_nxt.op     = p2_r.op;
    side3_nxt.mask   = p2_r.mask;
    side3_nxt.an     = p2_r.an;
    side3_nxt.bn     = p2_r.bn;
    side3_nxt.fault  = p2_r.fault;
    side3_nxt.simple = simple2_r;
    side3_nxt.prod   = '0;
  end
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      v3_r <= 1'b0;
    end else if (adv) begin
      v3_r <= v2_r;
    end
  end
  always_ff @(posedge clk) begin
    if (adv) begin
      side3_r <= side3_nxt;
      aa3_r   <= p2_r.aa;
      ba3_r   <= p2_r.ba;
    end
  end

  // product is ready alongside stage 3
  side_t side_div;
  always_comb begin
    side_div      = side3_r;
    side_div.prod = prod;
  end

  vwa_div u_div (
    .clk     (clk),
    .rst_n   (rst_n),
    .en      (adv),
    .in_vld  (v3_r),
    .dividend(aa3_r),
    .divisor (ba3_r),
    .side_in (side_div),
    .out_vld (vo),
    .quotient(quo),
    .side_out(side_o)
  );

  // result select, sign fix and truncation
  always_comb begin
    logic              neg;
    logic [DATA_W-1:0] r;
    neg = side_o.an ^ side_o.bn;
    case (side_o.op)
      OP_MUL:  r = neg ? (~side_o.prod + DATA_W'(1)) : side_o.prod;
      OP_DIV:  r = side_o.fault ? '0 : (neg ? (~quo + DATA_W'(1)) : quo);
      default: r = side_o.simple;
    endcase
    out_data_nxt.result_bits = r & side_o.mask;
    out_data_nxt.fault       = side_o.fault;
  end

  // output register
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      out_valid_r <= 1'b0;
    end else if (adv) begin
      out_valid_r <= vo;
    end
  end
  always_ff @(posedge clk) begin
    if (adv) begin
      out_data_r <= out_data_nxt;
    end
  end

  assign out_valid = out_valid_r;
  assign out_data  = out_data_r;

  `VWA_ASSERT_IMP(a_fault_zero, out_valid_r && out_data_r.fault, out_data_r.result_bits == '0)
  `VWA_ASSERT_NXT(a_accept_s1, in_valid && !in_stall, v1_r)
  `VWA_ASSERT_NXT(a_hold_s3, !adv, $stable(v3_r) && $stable(aa3_r))
  `VWA_ASSERT_IMP(a_div_fault, v3_r && side3_r.fault && side3_r.op == OP_DIV, ba3_r == '0)

endmodule

/* rtl/vwa_prep.sv */
// ----------------------------------------------------------------------------
// vwa_prep
// Width decode, operand truncation, sign and magnitude extraction.
// ----------------------------------------------------------------------------
module vwa_prep import vwa_pkg::*; (
  input  in_t   din,
  output prep_t dout
);

  logic [WID_W-1:0]  w;
  logic [DATA_W-1:0] mask, top, a, b;
  logic              an, bn;

  // clamp width to 1..MAX_WIDTH
  always_comb begin
    if (din.op_width == '0) begin
      w = WID_W'(1);
    end else if (din.op_width > WID_W'(MAX_WIDTH)) begin
      w = WID_W'(MAX_WIDTH);
    end else begin
      w = din.op_width;
    end
  end

  assign mask = {DATA_W{1'b1}} >> (WID_W'(DATA_W) - w);
  assign top  = {{(DATA_W-1){1'b0}}, 1'b1} << (w - WID_W'(1));
  assign a    = din.operand_a & mask;
  assign b    = din.operand_b & mask;
  assign an   = din.is_signed & (|(a & top));
  assign bn   = din.is_signed & (|(b & top));

  // sign and magnitude
  always_comb begin
    dout      = '0;
    dout.op   = din.action;
    dout.w    = w;
    dout.mask = mask;
    dout.top  = top;
    dout.a    = a;
    dout.b    = b;
    dout.aa   = an ? ((~a + DATA_W'(1)) & mask) : a;
    dout.ba   = bn ? ((~b + DATA_W'(1)) & mask) : b;
    dout.sgn  = din.is_signed;
    dout.an   = an;
    dout.bn   = bn;
    dout.fault = (din.action > OP_ASR) || ((din.action == OP_DIV) && (b == '0));
  end

endmodule

/* rtl/vwa_mul.sv */
// ----------------------------------------------------------------------------
// vwa_mul
// Two-stage magnitude multiplier, low DATA_W bits from half-width products.
// ----------------------------------------------------------------------------
module vwa_mul import vwa_pkg::*; (
  input  logic              clk,
  input  logic              en,
  input  logic [DATA_W-1:0] aa,
  input  logic [DATA_W-1:0] ba,
  output logic [DATA_W-1:0] prod
);

  logic [DATA_W-1:0] p_ll_r;
  logic [HALF_W-1:0] p_lh_r, p_hl_r;
  logic [DATA_W-1:0] prod_r;

  // partial products; cross terms only feed the upper half
  always_ff @(posedge clk) begin
    if (en) begin
      p_ll_r <= DATA_W'(aa[HALF_W-1:0]) * DATA_W'(ba[HALF_W-1:0]);
      p_lh_r <= aa[HALF_W-1:0] * ba[DATA_W-1:HALF_W];
      p_hl_r <= aa[DATA_W-1:HALF_W] * ba[HALF_W-1:0];
    end
  end

  // sum
  always_ff @(posedge clk) begin
    if (en) begin
      prod_r <= p_ll_r + {p_lh_r + p_hl_r, {HALF_W{1'b0}}};
    end
  end

  assign prod = prod_r;

endmodule

/* rtl/vwa_div.sv */
// ----------------------------------------------------------------------------
// vwa_div
// Pipelined restoring divider, one quotient bit per stage, with sideband.
// ----------------------------------------------------------------------------
module vwa_div import vwa_pkg::*; (
  input  logic              clk,
  input  logic              rst_n,
  input  logic              en,
  input  logic              in_vld,
  input  logic [DATA_W-1:0] dividend,
  input  logic [DATA_W-1:0] divisor,
  input  side_t             side_in,
  output logic              out_vld,
  output logic [DATA_W-1:0] quotient,
  output side_t             side_out
);

  logic              vld_r  [DIV_STAGES];
  logic [DATA_W-1:0] rem_r  [DIV_STAGES];
  logic [DATA_W-1:0] dq_r   [DIV_STAGES];
  logic [DATA_W-1:0] dsr_r  [DIV_STAGES];
  side_t             side_r [DIV_STAGES];

  for (genvar i = 0; i < DIV_STAGES; i++) begin : g_stage
    logic              vld_c;
    logic [DATA_W-1:0] rem_c, dq_c, dsr_c;
    side_t             side_c;
    logic [DATA_W:0]   sh, df;

    // stage input
    if (i == 0) begin : g_first
      assign vld_c  = in_vld;
      assign rem_c  = '0;
      assign dq_c   = dividend;
      assign dsr_c  = divisor;
      assign side_c = side_in;
    end else begin : g_next
      assign vld_c  = vld_r[i-1];
      assign rem_c  = rem_r[i-1];
      assign dq_c   = dq_r[i-1];
      assign dsr_c  = dsr_r[i-1];
      assign side_c = side_r[i-1];
    end

    // trial subtract
    assign sh = {rem_c, dq_c[DATA_W-1]};
    assign df = sh - {1'b0, dsr_c};

    always_ff @(posedge clk) begin
      if (!rst_n) begin
        vld_r[i] <= 1'b0;
      end else if (en) begin
        vld_r[i] <= vld_c;
      end
    end

    always_ff @(posedge clk) begin
      if (en) begin
        rem_r[i]  <= df[DATA_W] ? sh[DATA_W-1:0] : df[DATA_W-1:0];
        dq_r[i]   <= {dq_c[DATA_W-2:0], ~df[DATA_W]};
        dsr_r[i]  <= dsr_c;
        side_r[i] <= side_c;
      end
    end
  end

  assign out_vld  = vld_r[DIV_STAGES-1];
  assign quotient = dq_r[DIV_STAGES-1];
  assign side_out = side_r[DIV_STAGES-1];

endmodule
